@@ rtl/dual_incremental_pid_q10_defines.svh @@
// assertion macros for the dual incremental pid block
`ifndef DUAL_INCREMENTAL_PID_Q10_DEFINES_SVH
`define DUAL_INCREMENTAL_PID_Q10_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define DIPQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DIPQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define DIPQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define DIPQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ rtl/dipq_pkg.sv @@
// shared types and constants for the dual incremental pid block
package dipq_pkg;

    // field widths
    localparam int GAIN_W    = 16;
    localparam int LIMIT_W   = 31;
    localparam int SPEED_W   = 16;
    localparam int ERR_W     = SPEED_W + 1;
    localparam int ACC_W     = 32;
    localparam int MOTOR_W   = 32;
    localparam int Q_SHIFT   = 10;
    localparam int ADJ_W     = ACC_W - Q_SHIFT + 1;
    localparam int CFG_IDX_W = 3;

    // stages from transaction accept to output register
    localparam int PIPE_DEPTH = 6;

    // gain defaults after reset
    localparam logic [GAIN_W-1:0]  KP_RESET    = GAIN_W'(512);
    localparam logic [GAIN_W-1:0]  KI_RESET    = GAIN_W'(0);
    localparam logic [GAIN_W-1:0]  KD_RESET    = GAIN_W'(81);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(4096000);

    // bounds of the adjust value
    localparam logic signed [ADJ_W-1:0] ADJ_MAX = 23'sd2097152;
    localparam logic signed [ADJ_W-1:0] ADJ_MIN = -23'sd2097152;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KP_LEFT     = 3'd0,
        REG_KI_LEFT     = 3'd1,
        REG_KD_LEFT     = 3'd2,
        REG_LIMIT_LEFT  = 3'd3,
        REG_KP_RIGHT    = 3'd4,
        REG_KI_RIGHT    = 3'd5,
        REG_KD_RIGHT    = 3'd6,
        REG_LIMIT_RIGHT = 3'd7
    } cfg_reg_e_t;

    // per-channel gain set
    typedef struct packed {
        logic [GAIN_W-1:0]  kp;
        logic [GAIN_W-1:0]  ki;
        logic [GAIN_W-1:0]  kd;
        logic [LIMIT_W-1:0] limit;
    } gains_t;

    // stage loads and occupancy from the pipeline control
    typedef struct packed {
        logic [PIPE_DEPTH-1:0] load;
        logic [PIPE_DEPTH-1:0] valid;
    } pipe_ctrl_t;

endpackage

@@ rtl/dipq_in_if.sv @@
// input channel carrying one control tick for both wheels
interface dipq_in_if;
    import dipq_pkg::*;

    logic                        valid;
    logic                        ready;
    logic signed [SPEED_W-1:0]   left_setpoint;
    logic signed [SPEED_W-1:0]   left_measured;
    logic                        left_enable;
    logic signed [MOTOR_W-1:0]   left_motor_in;
    logic signed [SPEED_W-1:0]   right_setpoint;
    logic signed [SPEED_W-1:0]   right_measured;
    logic                        right_enable;
    logic signed [MOTOR_W-1:0]   right_motor_in;

    modport source (
        output valid, left_setpoint, left_measured, left_enable, left_motor_in,
               right_setpoint, right_measured, right_enable, right_motor_in,
        input  ready
    );

    modport sink (
        input  valid, left_setpoint, left_measured, left_enable, left_motor_in,
               right_setpoint, right_measured, right_enable, right_motor_in,
        output ready
    );
endinterface

@@ rtl/dipq_out_if.sv @@
// output channel carrying adjusted motor commands for both wheels
interface dipq_out_if;
    import dipq_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [ADJ_W-1:0]   left_adjust;
    logic signed [ADJ_W-1:0]   right_adjust;
    logic signed [MOTOR_W-1:0] left_motor_out;
    logic signed [MOTOR_W-1:0] right_motor_out;

    modport source (
        output valid, left_adjust, right_adjust, left_motor_out, right_motor_out,
        input  ready
    );

    modport sink (
        input  valid, left_adjust, right_adjust, left_motor_out, right_motor_out,
        output ready
    );
endinterface

@@ rtl/dipq_ctrl.sv @@
// stage occupancy and load control for the lane pipelines
module dipq_ctrl
    import dipq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       out_ready,
    output logic       out_valid,
    output pipe_ctrl_t ctrl
);

    logic [PIPE_DEPTH-1:0] valid_reg;
    logic [PIPE_DEPTH-1:0] valid_next;
    logic [PIPE_DEPTH-1:0] rdy;
    logic [PIPE_DEPTH-1:0] load;
    logic [PIPE_DEPTH-1:0] drain;

    // a stage can take a transaction when empty or when its content moves on
    always_comb
    begin
        rdy[PIPE_DEPTH-1] = !valid_reg[PIPE_DEPTH-1] || out_ready;
        for (int k = PIPE_DEPTH - 2; k >= 0; k--)
        begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    end

    // loads and drains per stage
    always_comb
    begin
        load[0] = in_valid && rdy[0];
        for (int k = 1; k < PIPE_DEPTH; k++)
        begin
            load[k] = valid_reg[k-1] && rdy[k];
        end
        for (int k = 0; k < PIPE_DEPTH - 1; k++)
        begin
            drain[k] = valid_reg[k] && rdy[k+1];
        end
        drain[PIPE_DEPTH-1] = valid_reg[PIPE_DEPTH-1] && out_ready;
        for (int k = 0; k < PIPE_DEPTH; k++)
        begin
            valid_next[k] = load[k] || (valid_reg[k] && !drain[k]);
        end
    end

    // occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready   = rdy[0];
    assign out_valid  = valid_reg[PIPE_DEPTH-1];
    assign ctrl.load  = load;
    assign ctrl.valid = valid_reg;

endmodule

@@ rtl/dipq_lane.sv @@
// one pid channel: error history, gain products, accumulator, clamp and motor sum
module dipq_lane
    import dipq_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  pipe_ctrl_t                ctrl,
    input  gains_t                    gains,
    input  logic signed [SPEED_W-1:0] setpoint,
    input  logic signed [SPEED_W-1:0] measured,
    input  logic                      enable,
    input  logic signed [MOTOR_W-1:0] motor_in,
    output logic signed [ADJ_W-1:0]   adjust,
    output logic signed [MOTOR_W-1:0] motor_out
);

    localparam int D1_W = ERR_W + 1;
    localparam int D2_W = ERR_W + 2;
    localparam int SH_W = ACC_W - Q_SHIFT;

    // error history
    logic signed [ERR_W-1:0]   e1_reg;
    logic signed [ERR_W-1:0]   e2_reg;
    logic signed [ERR_W-1:0]   err;
    logic signed [D1_W-1:0]    d1;
    logic signed [D2_W-1:0]    d2;

    // stage 1
    logic signed [ERR_W-1:0]   err1_reg;
    logic signed [D1_W-1:0]    d1_reg;
    logic signed [D2_W-1:0]    d2_reg;
    logic                      en1_reg;
    logic signed [MOTOR_W-1:0] motor1_reg;

    // stage 2
    logic signed [GAIN_W+D1_W:0]   pp_full;
    logic signed [GAIN_W+ERR_W:0]  pi_full;
    logic signed [GAIN_W+D2_W:0]   pd_full;
    logic [ACC_W-1:0]              pp2_reg;
    logic [ACC_W-1:0]              pi2_reg;
    logic [ACC_W-1:0]              pd2_reg;
    logic                          en2_reg;
    logic signed [MOTOR_W-1:0]     motor2_reg;

    // stage 3
    logic [ACC_W-1:0]          inc3_reg;
    logic                      en3_reg;
    logic signed [MOTOR_W-1:0] motor3_reg;

    // stage 4, the accumulator itself
    logic [ACC_W-1:0]          acc_reg;
    logic signed [MOTOR_W-1:0] motor4_reg;

    // stage 5
    logic signed [ACC_W-1:0]   acc_s;
    logic signed [ACC_W-1:0]   lim_pos;
    logic signed [ACC_W-1:0]   lim_neg;
    logic signed [ACC_W-1:0]   clamped;
    logic signed [SH_W-1:0]    shifted;
    logic signed [ADJ_W-1:0]   adj;
    logic signed [ADJ_W-1:0]   adj5_reg;
    logic signed [MOTOR_W-1:0] motor5_reg;
    logic signed [MOTOR_W:0]   motor_sum;

    // error and its first and second differences
    assign err = {measured[SPEED_W-1], measured} - {setpoint[SPEED_W-1], setpoint};
    assign d1  = {err[ERR_W-1], err} - {e1_reg[ERR_W-1], e1_reg};
    assign d2  = {{2{err[ERR_W-1]}}, err} - {e1_reg[ERR_W-1], e1_reg, 1'b0}
               + {{2{e2_reg[ERR_W-1]}}, e2_reg};

    // history shifts on accept, cleared by a disabled tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_reg <= '0;
            e2_reg <= '0;
        end
        else if (ctrl.load[0])
        begin
            if (enable)
            begin
                e1_reg <= err;
                e2_reg <= e1_reg;
            end
            else
            begin
                e1_reg <= '0;
                e2_reg <= '0;
            end
        end
    end

    // stage 1 capture
    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
        begin
            err1_reg   <= err;
            d1_reg     <= d1;
            d2_reg     <= d2;
            en1_reg    <= enable;
            motor1_reg <= motor_in;
        end
    end

    // gain products, only the low word matters for the wrapping sum
    assign pp_full = $signed({1'b0, gains.kp}) * d1_reg;
    assign pi_full = $signed({1'b0, gains.ki}) * err1_reg;
    assign pd_full = $signed({1'b0, gains.kd}) * d2_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load[1])
        begin
            pp2_reg    <= pp_full[ACC_W-1:0];
            pi2_reg    <= pi_full[ACC_W-1:0];
            pd2_reg    <= pd_full[ACC_W-1:0];
            en2_reg    <= en1_reg;
            motor2_reg <= motor1_reg;
        end
    end

    // increment
    always_ff @(posedge clk)
    begin
        if (ctrl.load[2])
        begin
            inc3_reg   <= pp2_reg + pi2_reg + pd2_reg;
            en3_reg    <= en2_reg;
            motor3_reg <= motor2_reg;
        end
    end

    // accumulator, wraps modulo two to the word width
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.load[3])
        begin
            acc_reg <= en3_reg ? (acc_reg + inc3_reg) : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[3])
        begin
            motor4_reg <= motor3_reg;
        end
    end

    // clamp to plus or minus limit, drop the fraction, negate
    always_comb
    begin
        acc_s   = $signed(acc_reg);
        lim_pos = $signed({1'b0, gains.limit});
        lim_neg = -lim_pos;
        if (acc_s > lim_pos)
        begin
            clamped = lim_pos;
        end
        else if (acc_s < lim_neg)
        begin
            clamped = lim_neg;
        end
        else
        begin
            clamped = acc_s;
        end
        shifted = clamped[ACC_W-1:Q_SHIFT];
        adj     = -$signed({shifted[SH_W-1], shifted});
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[4])
        begin
            adj5_reg   <= adj;
            motor5_reg <= motor4_reg;
        end
    end

    // saturating motor sum
    always_comb
    begin
        motor_sum = {motor5_reg[MOTOR_W-1], motor5_reg}
                  + {{(MOTOR_W + 1 - ADJ_W){adj5_reg[ADJ_W-1]}}, adj5_reg};
        if (motor_sum[MOTOR_W] != motor_sum[MOTOR_W-1])
        begin
            motor_out = motor_sum[MOTOR_W] ? {1'b1, {(MOTOR_W - 1){1'b0}}}
                                           : {1'b0, {(MOTOR_W - 1){1'b1}}};
        end
        else
        begin
            motor_out = motor_sum[MOTOR_W-1:0];
        end
    end

    assign adjust = adj5_reg;

endmodule

@@ rtl/dual_incremental_pid_q10.sv @@
// two-lane incremental pid: six register stages, result valid once the output register is loaded
// throughput one transaction per cycle unless output stalls; accumulator loop closes in one add
// the output register merges both lanes and lets a new transaction in while a result waits
// reset clears pipeline occupancy, accumulators and error history, and restores the gains
// no clearing pass; the block takes transactions from the first cycle after reset
`include "dual_incremental_pid_q10_defines.svh"

module dual_incremental_pid_q10
    import dipq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    dipq_in_if.sink              sample,
    dipq_out_if.source           command,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LIMIT_W-1:0]   cfg_data
);

    gains_t                    gains_left_reg;
    gains_t                    gains_right_reg;
    pipe_ctrl_t                ctrl;
    logic                      out_valid;
    logic signed [ADJ_W-1:0]   adj_left;
    logic signed [ADJ_W-1:0]   adj_right;
    logic signed [MOTOR_W-1:0] motor_left;
    logic signed [MOTOR_W-1:0] motor_right;
    logic signed [ADJ_W-1:0]   adj_left_reg;
    logic signed [ADJ_W-1:0]   adj_right_reg;
    logic signed [MOTOR_W-1:0] motor_left_reg;
    logic signed [MOTOR_W-1:0] motor_right_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_left_reg  <= '{kp: KP_RESET, ki: KI_RESET, kd: KD_RESET, limit: LIMIT_RESET};
            gains_right_reg <= '{kp: KP_RESET, ki: KI_RESET, kd: KD_RESET, limit: LIMIT_RESET};
        end
        else if (cfg_we)
        begin
            case (cfg_reg_e_t'(cfg_index))
                REG_KP_LEFT:     gains_left_reg.kp     <= cfg_data[GAIN_W-1:0];
                REG_KI_LEFT:     gains_left_reg.ki     <= cfg_data[GAIN_W-1:0];
                REG_KD_LEFT:     gains_left_reg.kd     <= cfg_data[GAIN_W-1:0];
                REG_LIMIT_LEFT:  gains_left_reg.limit  <= cfg_data;
                REG_KP_RIGHT:    gains_right_reg.kp    <= cfg_data[GAIN_W-1:0];
                REG_KI_RIGHT:    gains_right_reg.ki    <= cfg_data[GAIN_W-1:0];
                REG_KD_RIGHT:    gains_right_reg.kd    <= cfg_data[GAIN_W-1:0];
                REG_LIMIT_RIGHT: gains_right_reg.limit <= cfg_data;
                default:         gains_left_reg        <= gains_left_reg;
            endcase
        end
    end

    // pipeline control shared by both lanes
    dipq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_ready  (sample.ready),
        .out_ready (command.ready),
        .out_valid (out_valid),
        .ctrl      (ctrl)
    );

    // left lane
    dipq_lane u_lane_left (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .gains     (gains_left_reg),
        .setpoint  (sample.left_setpoint),
        .measured  (sample.left_measured),
        .enable    (sample.left_enable),
        .motor_in  (sample.left_motor_in),
        .adjust    (adj_left),
        .motor_out (motor_left)
    );

    // right lane
    dipq_lane u_lane_right (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .gains     (gains_right_reg),
        .setpoint  (sample.right_setpoint),
        .measured  (sample.right_measured),
        .enable    (sample.right_enable),
        .motor_in  (sample.right_motor_in),
        .adjust    (adj_right),
        .motor_out (motor_right)
    );

    // merge both lanes into the output register
    always_ff @(posedge clk)
    begin
        if (ctrl.load[PIPE_DEPTH-1])
        begin
            adj_left_reg    <= adj_left;
            adj_right_reg   <= adj_right;
            motor_left_reg  <= motor_left;
            motor_right_reg <= motor_right;
        end
    end

    assign command.valid           = out_valid;
    assign command.left_adjust     = adj_left_reg;
    assign command.right_adjust    = adj_right_reg;
    assign command.left_motor_out  = motor_left_reg;
    assign command.right_motor_out = motor_right_reg;

    // checks
    `DIPQ_ASSERT_IMP(a_accept_when_first_stage_free, clk, rst_n,
                     !ctrl.valid[0], sample.ready, "input stalled with first stage empty")
    `DIPQ_ASSERT_NXT(a_last_stage_reaches_output, clk, rst_n,
                     ctrl.load[PIPE_DEPTH-1], command.valid, "loaded result not presented")
    `DIPQ_ASSERT_IMP(a_adjust_in_range, clk, rst_n, command.valid,
                     (command.left_adjust >= ADJ_MIN) && (command.left_adjust <= ADJ_MAX)
                     && (command.right_adjust >= ADJ_MIN) && (command.right_adjust <= ADJ_MAX),
                     "adjust outside clamp range")

endmodule
